@@ design/pwc_pkg.sv @@
package pwc_pkg;

   // Operation codes carried by one input beat.
   typedef enum logic [2:0] {
      OP_REG_WRITE    = 3'd0,
      OP_ENABLE_WRITE = 3'd1,
      OP_CPU_TICK     = 3'd2,
      OP_QUARTER      = 3'd3,
      OP_HALF         = 3'd4
   } op_type;

   // Channel register indexes for a register write.
   typedef enum logic [1:0] {
      REG_CONTROL     = 2'd0,
      REG_SWEEP       = 2'd1,
      REG_TIMER_LOW   = 2'd2,
      REG_LENGTH_HIGH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] reg_index;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [3:0] sample;
      logic       length_active;
   } result_type;

   localparam logic [10:0] PERIOD_MAX = 11'h7FF;
   localparam logic [10:0] PERIOD_MIN = 11'd8;

   localparam logic [7:0] DUTY_TABLE [4] = '{
      8'b0000_0010,
      8'b0000_0110,
      8'b0001_1110,
      8'b1111_1001
   };

   localparam logic [7:0] LENGTH_TABLE [32] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

   // Sweep target in 13-bit two's complement; it can dip to -1 in negate mode.
   function automatic logic [12:0] sweep_target(input logic [10:0] period,
                                                input logic [7:0]  sweep,
                                                input logic        first);
      logic [10:0] delta;
      logic [12:0] target;
      delta = period >> sweep[2:0];
      if (sweep[3]) begin
         target = {2'b00, period} - {2'b00, delta} - {12'd0, first};
      end else begin
         target = {2'b00, period} + {2'b00, delta};
      end
      return target;
   endfunction

   function automatic logic sweep_enabled(input logic [7:0] sweep);
      return sweep[7] && (sweep[2:0] != 3'd0);
   endfunction

   function automatic logic channel_muted(input logic [10:0] period,
                                          input logic [7:0]  sweep,
                                          input logic        first);
      logic [12:0] target;
      target = sweep_target(period, sweep, first);
      // Positive targets stay below 4096, so bit 11 alone marks overflow.
      return (period < PERIOD_MIN) ||
             (sweep_enabled(sweep) && !target[12] && target[11]);
   endfunction

   function automatic logic duty_level(input logic [1:0] duty, input logic [2:0] step);
      logic [7:0] row;
      row = DUTY_TABLE[duty];
      return row[step];
   endfunction

endpackage

@@ design/pwc_core.sv @@
module pwc_core
   import pwc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  logic       first_pulse_channel,
   output result_type result
);

   logic [7:0]  control_ff,    control_in;
   logic [7:0]  sweep_ff,      sweep_in;
   logic [10:0] period_ff,     period_in;
   logic [12:0] count_ff,      count_in;
   logic [2:0]  duty_step_ff,  duty_step_in;
   logic [7:0]  length_ff,     length_in;
   logic        enable_ff,     enable_in;
   logic        env_start_ff,  env_start_in;
   logic [3:0]  env_div_ff,    env_div_in;
   logic [3:0]  env_decay_ff,  env_decay_in;
   logic [2:0]  sweep_div_ff,  sweep_div_in;
   logic        sweep_load_ff, sweep_load_in;

   logic [12:0] target;
   logic        muted_now;
   logic [3:0]  volume;

   always_comb begin
      control_in    = control_ff;
      sweep_in      = sweep_ff;
      period_in     = period_ff;
      count_in      = count_ff;
      duty_step_in  = duty_step_ff;
      length_in     = length_ff;
      enable_in     = enable_ff;
      env_start_in  = env_start_ff;
      env_div_in    = env_div_ff;
      env_decay_in  = env_decay_ff;
      sweep_div_in  = sweep_div_ff;
      sweep_load_in = sweep_load_ff;

      target    = sweep_target(period_ff, sweep_ff, first_pulse_channel);
      muted_now = channel_muted(period_ff, sweep_ff, first_pulse_channel);

      case (op_type'(item.op))
         OP_REG_WRITE: begin
            case (reg_index_type'(item.reg_index))
               REG_CONTROL: begin
                  control_in = item.data;
               end
               REG_SWEEP: begin
                  sweep_in      = item.data;
                  sweep_load_in = 1'b1;
               end
               REG_TIMER_LOW: begin
                  period_in = {period_ff[10:8], item.data};
               end
               REG_LENGTH_HIGH: begin
                  period_in = {item.data[2:0], period_ff[7:0]};
                  if (enable_ff) begin
                     length_in = LENGTH_TABLE[item.data[7:3]];
                  end
                  env_start_in = 1'b1;
                  duty_step_in = 3'd0;
                  count_in     = 13'd0;
               end
               default: begin
               end
            endcase
         end
         OP_ENABLE_WRITE: begin
            enable_in = item.data[0];
            if (!item.data[0]) begin
               length_in = 8'd0;
            end
         end
         OP_CPU_TICK: begin
            // Reload adds twice the period plus one, which nets out the
            // decrement of this cycle.
            if (count_ff <= 13'd1) begin
               count_in     = count_ff + {1'b0, period_ff, 1'b1};
               duty_step_in = duty_step_ff + 3'd1;
            end else begin
               count_in = count_ff - 13'd1;
            end
         end
         OP_QUARTER: begin
            if (env_start_ff) begin
               env_start_in = 1'b0;
               env_decay_in = 4'd15;
               env_div_in   = control_ff[3:0];
            end else if (env_div_ff == 4'd0) begin
               env_div_in = control_ff[3:0];
               if (env_decay_ff != 4'd0) begin
                  env_decay_in = env_decay_ff - 4'd1;
               end else if (control_ff[5]) begin
                  env_decay_in = 4'd15;
               end
            end else begin
               env_div_in = env_div_ff - 4'd1;
            end
         end
         OP_HALF: begin
            if ((length_ff != 8'd0) && !control_ff[5]) begin
               length_in = length_ff - 8'd1;
            end
            if (sweep_div_ff == 3'd0) begin
               if (sweep_enabled(sweep_ff) && !muted_now) begin
                  period_in = target[10:0] & PERIOD_MAX;
               end
               sweep_div_in = sweep_ff[6:4];
            end else begin
               sweep_div_in = sweep_div_ff - 3'd1;
            end
            if (sweep_load_ff) begin
               sweep_div_in  = sweep_ff[6:4];
               sweep_load_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // The reported level reflects the state after this beat is applied.
      volume = control_in[4] ? control_in[3:0] : env_decay_in;
      if (!enable_in || (length_in == 8'd0) || (volume == 4'd0) ||
          channel_muted(period_in, sweep_in, first_pulse_channel)) begin
         result.sample = 4'd0;
      end else begin
         result.sample = duty_level(control_in[7:6], duty_step_in) ? volume : 4'd0;
      end
      result.length_active = (length_in != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff    <= '0;
         sweep_ff      <= '0;
         period_ff     <= '0;
         count_ff      <= '0;
         duty_step_ff  <= '0;
         length_ff     <= '0;
         enable_ff     <= 1'b0;
         env_start_ff  <= 1'b0;
         env_div_ff    <= '0;
         env_decay_ff  <= '0;
         sweep_div_ff  <= '0;
         sweep_load_ff <= 1'b0;
      end else if (fire) begin
         control_ff    <= control_in;
         sweep_ff      <= sweep_in;
         period_ff     <= period_in;
         count_ff      <= count_in;
         duty_step_ff  <= duty_step_in;
         length_ff     <= length_in;
         enable_ff     <= enable_in;
         env_start_ff  <= env_start_in;
         env_div_ff    <= env_div_in;
         env_decay_ff  <= env_decay_in;
         sweep_div_ff  <= sweep_div_in;
         sweep_load_ff <= sweep_load_in;
      end
   end

endmodule

@@ design/pulse_wave_channel_unit.sv @@
// Channel   Direction  Ports                                    Handshake
// req       in         req_op, req_reg_index, req_data          req_valid / req_stall
// rsp       out        rsp_sample, rsp_length_active            rsp_valid / rsp_stall
// csr       in         csr_wr_en, csr_wr_data                   write on enable, no wait
//
// Every request beat yields exactly one response beat: it is held in the input
// register, then passes through the channel update into the response register.
// A new beat is taken in every cycle while req_stall is low, so the sustained
// rate is one beat per clock when rsp does not stall. The response register is
// the only point where a stall on rsp pushes back; req_stall rises only while
// the input register holds a beat that cannot move on. Synchronous reset clears
// all channel state and sets the first-channel flag.
module pulse_wave_channel_unit
   import pwc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [1:0] req_reg_index,
   input  logic [7:0] req_data,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_sample,
   output logic       rsp_length_active,

   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   // Input register and its valid flag.
   item_type   item_ff;
   logic       item_valid_ff;

   // Response register.
   result_type rsp_ff;
   logic       rsp_valid_ff;

   logic       first_ff;

   result_type core_result;
   logic       advance;
   logic       fire;

   // The response register can take a new beat when it is empty or when its
   // current beat leaves at this edge.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && advance;
   assign req_stall = item_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.op        <= req_op;
         item_ff.reg_index <= req_reg_index;
         item_ff.data      <= req_data;
      end
   end

   // The first-channel flag selects the ones' complement negate of the sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (csr_wr_en) begin
         first_ff <= csr_wr_data;
      end
   end

   pwc_core u_core (
      .clock               (clock),
      .reset               (reset),
      .fire                (fire),
      .item                (item_ff),
      .first_pulse_channel (first_ff),
      .result              (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_ff.sample;
   assign rsp_length_active = rsp_ff.length_active;

endmodule
